// ===== rtl/core/lkvc_pkg.sv =====
`timescale 1ns / 1ps

package lkvc_pkg;

  // width of the capacity register and of the occupancy count
  localparam int unsigned CNT_W = 5;

  // capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  typedef enum logic [1:0] {
    OP_GET      = 2'd0,
    OP_PUT      = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  // lookup status handed from the match logic to the update logic
  typedef struct packed {
    logic hit;   // key found in a valid entry
    logic full;  // occupancy has reached the effective capacity
  } lookup_flags_t;

endpackage

// ===== rtl/core/lkvc_lookup.sv =====
`timescale 1ns / 1ps

module lkvc_lookup #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [KEY_BITS-1:0]          ent_key_i [ENTRIES],
  input  logic [ENTRIES-1:0]           ent_vld_i,
  input  logic [lkvc_pkg::CNT_W-1:0]   rank_i    [ENTRIES],
  input  logic [lkvc_pkg::CNT_W-1:0]   cnt_i,
  input  logic [lkvc_pkg::CNT_W-1:0]   cap_i,
  output logic [ENTRIES-1:0]           hit_vec_o,
  output logic [ENTRIES-1:0]           victim_vec_o,
  output logic [ENTRIES-1:0]           free_vec_o,
  output lkvc_pkg::lookup_flags_t      flags_o
);

  // parallel key compare and least recent entry detect
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec_o[i]    = ent_vld_i[i] && (ent_key_i[i] == key_i);
      victim_vec_o[i] = ent_vld_i[i] &&
                        ((rank_i[i] + lkvc_pkg::CNT_W'(1)) == cnt_i);
    end
  end

  // lowest invalid slot
  assign free_vec_o = ~ent_vld_i & (ent_vld_i + ENTRIES'(1));

  assign flags_o.hit  = |hit_vec_o;
  assign flags_o.full = (cnt_i >= cap_i);

endmodule

// ===== rtl/core/lru_key_value_cache_unit.sv =====
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement.
// Each input beat carries an op (get, put, contains, clear), a key and a value;
// each one produces exactly one result beat with hit, read_value, evicted,
// evicted_key and occupancy. The block takes one beat per clock cycle while the
// result channel is not stalled: a beat is captured in an input register, and once
// the result register can advance, the key compare against all ENTRIES slots, the
// recency rank and slot content update and the result load into the output register
// happen together. The rate is set by that combinational compare and rank update
// path, which spans every slot at once. The capacity register is written through
// the cfg channel (always ready); the user must write it only while the block is
// idle, the block itself does not enforce this. 0 acts as 1 and values above
// ENTRIES act as ENTRIES. Lowering capacity below the current occupancy does not
// shrink the store, a put miss evicts only one.

module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lkvc_pkg::CNT_W-1:0]  cfg_capacity_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  in_op_i,
  input  logic [KEY_BITS-1:0]         in_key_i,
  input  logic [VALUE_BITS-1:0]       in_value_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        out_hit_o,
  output logic [VALUE_BITS-1:0]       out_read_value_o,
  output logic                        out_evicted_o,
  output logic [KEY_BITS-1:0]         out_evicted_key_o,
  output logic [lkvc_pkg::CNT_W-1:0]  out_occupancy_o
);

  localparam int unsigned CW = lkvc_pkg::CNT_W;

  // input register
  logic                  in_vld_q;
  lkvc_pkg::op_e         op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  // cache state
  logic [KEY_BITS-1:0]   ent_key_q [ENTRIES];
  logic [VALUE_BITS-1:0] ent_val_q [ENTRIES];
  logic [ENTRIES-1:0]    ent_vld_q, ent_vld_d;
  logic [CW-1:0]         rank_q [ENTRIES];
  logic [CW-1:0]         rank_d [ENTRIES];
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         cap_q;
  logic [CW-1:0]         cap_eff;

  // result register
  logic                  out_vld_q;
  logic                  out_hit_q, out_hit_d;
  logic [VALUE_BITS-1:0] out_rd_q, out_rd_d;
  logic                  out_ev_q, out_ev_d;
  logic [KEY_BITS-1:0]   out_evk_q, out_evk_d;
  logic [CW-1:0]         out_occ_q;

  // lookup results
  logic [ENTRIES-1:0]      hit_vec, victim_vec, free_vec;
  lkvc_pkg::lookup_flags_t flags;

  // write control for slot contents
  logic [ENTRIES-1:0]      key_we, val_we;

  logic advance;  // result register can take a new beat
  logic fire;     // the held request is processed this cycle
  logic in_take;

  assign advance    = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  // clamp the capacity to 1..ENTRIES
  always_comb begin
    cap_eff = cap_q;
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > 32'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end
  end

  lkvc_lookup #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_lookup (
    .key_i        (key_q),
    .ent_key_i    (ent_key_q),
    .ent_vld_i    (ent_vld_q),
    .rank_i       (rank_q),
    .cnt_i        (cnt_q),
    .cap_i        (cap_eff),
    .hit_vec_o    (hit_vec),
    .victim_vec_o (victim_vec),
    .free_vec_o   (free_vec),
    .flags_o      (flags)
  );

  // next state and result for the held request
  always_comb begin
    logic [CW-1:0]         hit_rank;
    logic [VALUE_BITS-1:0] hit_val;
    logic [KEY_BITS-1:0]   vic_key;
    logic [ENTRIES-1:0]    ins_vec;
    logic [ENTRIES-1:0]    kept_vld;
    logic                  evict;

    hit_rank = '0;
    hit_val  = '0;
    vic_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_rank = hit_rank | rank_q[i];
        hit_val  = hit_val | ent_val_q[i];
      end
      if (victim_vec[i]) begin
        vic_key = vic_key | ent_key_q[i];
      end
    end

    evict    = (op_q == lkvc_pkg::OP_PUT) && !flags.hit && flags.full;
    ins_vec  = evict ? victim_vec : free_vec;
    kept_vld = evict ? (ent_vld_q & ~victim_vec) : ent_vld_q;

    ent_vld_d = ent_vld_q;
    cnt_d     = cnt_q;
    rank_d    = rank_q;
    key_we    = '0;
    val_we    = '0;
    out_hit_d = flags.hit;
    out_rd_d  = '0;
    out_ev_d  = 1'b0;
    out_evk_d = '0;

    case (op_q)
      lkvc_pkg::OP_CLEAR: begin
        out_hit_d = 1'b0;
        ent_vld_d = '0;
        cnt_d     = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          rank_d[i] = '0;
        end
      end
      lkvc_pkg::OP_GET, lkvc_pkg::OP_PUT: begin
        if (flags.hit) begin
          // promote: entries more recent than the hit age by one
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit_vec[i]) begin
              rank_d[i] = '0;
            end else if (ent_vld_q[i] && (rank_q[i] < hit_rank)) begin
              rank_d[i] = rank_q[i] + CW'(1);
            end
          end
          if (op_q == lkvc_pkg::OP_GET) begin
            out_rd_d = hit_val;
          end else begin
            val_we = hit_vec;
          end
        end else if (op_q == lkvc_pkg::OP_PUT) begin
          // insert as most recent, reusing the victim slot when full
          for (int i = 0; i < ENTRIES; i++) begin
            if (ins_vec[i]) begin
              rank_d[i] = '0;
            end else if (kept_vld[i]) begin
              rank_d[i] = rank_q[i] + CW'(1);
            end
          end
          ent_vld_d = kept_vld | ins_vec;
          key_we    = ins_vec;
          val_we    = ins_vec;
          cnt_d     = evict ? cnt_q : (cnt_q + CW'(1));
          out_ev_d  = evict;
          out_evk_d = evict ? vic_key : '0;
        end
      end
      default: begin
        // contains: lookup only
      end
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= lkvc_pkg::op_e'(in_op_i);
      key_q <= in_key_i;
      val_q <= in_value_i;
    end
  end

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_capacity_i;
    end
  end

  // control state of the cache
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      cnt_q     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (fire) begin
      ent_vld_q <= ent_vld_d;
      cnt_q     <= cnt_d;
      rank_q    <= rank_d;
    end
  end

  // slot contents, undefined until written
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fire && key_we[i]) begin
        ent_key_q[i] <= key_q;
      end
      if (fire && val_we[i]) begin
        ent_val_q[i] <= val_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_hit_q <= out_hit_d;
      out_rd_q  <= out_rd_d;
      out_ev_q  <= out_ev_d;
      out_evk_q <= out_evk_d;
      out_occ_q <= cnt_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign out_hit_o         = out_hit_q;
  assign out_read_value_o  = out_rd_q;
  assign out_evicted_o     = out_ev_q;
  assign out_evicted_key_o = out_evk_q;
  assign out_occupancy_o   = out_occ_q;

`ifndef SYNTHESIS
  // occupancy count tracks the valid bits
  a_cnt_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(ent_vld_q)) == 32'(cnt_q))
    else $error("occupancy count out of step with valid entries");

  // a key is never held by two valid slots
  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> $onehot0(hit_vec))
    else $error("duplicate key in cache");

  // an eviction only follows a put miss
  a_evict_put_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && out_ev_d |=> out_vld_q && out_ev_q && !out_hit_q)
    else $error("eviction reported with a hit");

  // a put miss on a full store always finds a least recent slot
  a_victim_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op_q == lkvc_pkg::OP_PUT) && !flags.hit && flags.full |-> $onehot(victim_vec))
    else $error("no unique least recent entry");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_W   = lkvc_pkg::CNT_W;

  // one result beat as seen on the output ports
  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic [CNT_W-1:0]  occupancy;
  } reply_t;

  // shadow copy of the cache contents; every accepted request is applied here
  // and the resulting reply is queued until the block produces its own
  class cache_mirror;
    bit [KEY_W-1:0]   slot_key[ENTRIES];
    bit [VAL_W-1:0]   slot_value[ENTRIES];
    bit               slot_used[ENTRIES];
    int unsigned      slot_age[ENTRIES];   // 0 is most recent
    int unsigned      used_count;
    bit [CNT_W-1:0]   capacity;
    reply_t           due_replies[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      hits;
    int unsigned      evictions;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_age[i]  = 0;
      end
      used_count = 0;
      capacity   = lkvc_pkg::CAP_RESET;
      mismatches = 0;
      checked    = 0;
      hits       = 0;
      evictions  = 0;
    endfunction

    function void set_capacity(bit [CNT_W-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned outstanding();
      return due_replies.size();
    endfunction

    // entries more recent than slot s age by one, s becomes most recent
    function void promote(int s);
      int unsigned old_age;
      old_age = slot_age[s];
      foreach (slot_used[i])
        if (slot_used[i] && slot_age[i] < old_age) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    function void note_request(lkvc_pkg::op_e op, bit [KEY_W-1:0] key,
                               bit [VAL_W-1:0] value);
      reply_t      want;
      int          found;
      int          slot;
      int unsigned limit;
      want  = '0;
      // out of range capacity clamps to 1..ENTRIES
      limit = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
      if (op == lkvc_pkg::OP_CLEAR) begin
        foreach (slot_used[i]) begin
          slot_used[i] = 1'b0;
          slot_age[i]  = 0;
        end
        used_count = 0;
      end else begin
        found = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (slot_used[i] && slot_key[i] == key) found = i;
        want.hit = (found >= 0);
        if (op == lkvc_pkg::OP_GET && found >= 0) begin
          want.read_value = slot_value[found];
          promote(found);
        end else if (op == lkvc_pkg::OP_PUT) begin
          if (found >= 0) begin
            slot_value[found] = value;
            promote(found);
          end else begin
            slot = -1;
            // full: drop the least recent entry, only one even if over capacity
            if (used_count >= limit) begin
              foreach (slot_used[i])
                if (slot_used[i] && slot_age[i] + 1 == used_count) slot = i;
              if (slot >= 0) begin
                want.evicted     = 1'b1;
                want.evicted_key = slot_key[slot];
                slot_used[slot]  = 1'b0;
                used_count--;
              end
            end
            if (slot < 0)
              for (int i = ENTRIES - 1; i >= 0; i--)
                if (!slot_used[i]) slot = i;
            if (slot >= 0) begin
              foreach (slot_used[i])
                if (slot_used[i]) slot_age[i]++;
              slot_key[slot]   = key;
              slot_value[slot] = value;
              slot_used[slot]  = 1'b1;
              slot_age[slot]   = 0;
              used_count++;
            end
          end
        end
      end
      want.occupancy = CNT_W'(used_count);
      due_replies.push_back(want);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected reply beat, expected none actual 0x%0h", $time, got);
        return;
      end
      want = due_replies.pop_front();
      checked++;
      if (want.hit) hits++;
      if (want.evicted) evictions++;
      compare("hit", 32'(want.hit), 32'(got.hit));
      compare("read_value", want.read_value, got.read_value);
      compare("evicted", 32'(want.evicted), 32'(got.evicted));
      compare("evicted_key", want.evicted_key, got.evicted_key);
      compare("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CNT_W-1:0]  cfg_capacity_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        in_op_i;
  logic [KEY_W-1:0]  in_key_i;
  logic [VAL_W-1:0]  in_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              out_hit_o;
  logic [VAL_W-1:0]  out_read_value_o;
  logic              out_evicted_o;
  logic [KEY_W-1:0]  out_evicted_key_o;
  logic [CNT_W-1:0]  out_occupancy_o;

  cache_mirror mirror = new();

  // idle limits per beat, changed per phase to get both gappy and back to back traffic
  int unsigned tx_wait_max = 9;
  int unsigned rx_wait_max = 9;
  logic        rx_hold;
  int unsigned n_sent = 0;
  int unsigned n_cap_writes = 0;

  lru_key_value_cache_unit #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_W),
    .VALUE_BITS (VAL_W)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_capacity_i    (cfg_capacity_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_op_i           (in_op_i),
    .in_key_i          (in_key_i),
    .in_value_i        (in_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_hit_o         (out_hit_o),
    .out_read_value_o  (out_read_value_o),
    .out_evicted_o     (out_evicted_o),
    .out_evicted_key_o (out_evicted_key_o),
    .out_occupancy_o   (out_occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // one request beat: optional idle gap, then hold the beat until accepted.
  // valid stays high when the next beat follows with no gap
  task automatic send_request(input lkvc_pkg::op_e op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = $urandom_range(0, tx_wait_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_op_i    <= op;
    in_key_i   <= key;
    in_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_request(op, key, value);
    n_sent++;
  endtask

  // capacity may only change while nothing is in flight
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    in_valid_i <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mirror.set_capacity(cap);
    n_cap_writes++;
  endtask

  // result side: random stall per beat, plus the long hold-off
  initial begin : reply_sink
    int unsigned wait_left;
    reply_t      got;
    wait_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.hit         = out_hit_o;
        got.read_value  = out_read_value_o;
        got.evicted     = out_evicted_o;
        got.evicted_key = out_evicted_key_o;
        got.occupancy   = out_occupancy_o;
        mirror.check_result(got);
        wait_left = $urandom_range(0, rx_wait_max);
      end
      if (rx_hold) begin
        out_stall_i <= 1'b1;
      end else if (wait_left > 0) begin
        out_stall_i <= 1'b1;
        wait_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // long back-pressure mid run so the pipeline fills and stalls its input
  initial begin : long_backpressure
    rx_hold <= 1'b0;
    wait (n_sent >= 300);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (120) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] key_pool[24];
    int unsigned      pool_n;
    int unsigned      limit;
    int unsigned      pick;
    logic [CNT_W-1:0] cap;
    logic [KEY_W-1:0] key;
    lkvc_pkg::op_e    op;
    int unsigned      cap_plan[8];

    cap_plan       = '{16, 1, 31, 5, 2, 8, 17, 0};
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_capacity_i <= '0;
    in_valid_i     <= 1'b0;
    in_op_i        <= lkvc_pkg::OP_GET;
    in_key_i       <= '0;
    in_value_i     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: small store so evictions show up quickly
    write_capacity(CNT_W'(3));
    send_request(lkvc_pkg::OP_GET, 32'h0, 32'h0);                 // miss on empty store
    send_request(lkvc_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0);
    send_request(lkvc_pkg::OP_PUT, 32'h1, 32'h5A5A_A5A5);         // store now full
    send_request(lkvc_pkg::OP_CONTAINS, 32'h0, 32'h0);            // hit, no promotion
    send_request(lkvc_pkg::OP_PUT, 32'h2, 32'h1);                 // key 0 still oldest
    send_request(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);         // hit, promotes
    send_request(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678); // update in place
    send_request(lkvc_pkg::OP_PUT, 32'h3, 32'h3);                 // evicts key 1
    send_request(lkvc_pkg::OP_GET, 32'h2, 32'h0);
    send_request(lkvc_pkg::OP_GET, 32'h0, 32'hDEAD_BEEF);         // miss, value ignored

    // capacity dropped under occupancy: one eviction per insert, no shrink
    write_capacity(CNT_W'(1));
    send_request(lkvc_pkg::OP_PUT, 32'h4, 32'h4);
    send_request(lkvc_pkg::OP_GET, 32'h3, 32'h0);
    send_request(lkvc_pkg::OP_PUT, 32'h3, 32'hFFFF_FFFF);         // hit needs no eviction

    // zero capacity behaves as one
    write_capacity(CNT_W'(0));
    send_request(lkvc_pkg::OP_PUT, 32'h5, 32'h5);
    send_request(lkvc_pkg::OP_CLEAR, 32'h5, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::OP_GET, 32'h5, 32'h0);
    send_request(lkvc_pkg::OP_PUT, 32'h6, 32'h6);
    send_request(lkvc_pkg::OP_PUT, 32'h7, 32'h7);

    // random phases, each with its own capacity, key pool and idle profile
    for (int p = 0; p < 10; p++) begin
      cap = (p < 8) ? CNT_W'(cap_plan[p]) : CNT_W'($urandom_range(0, 31));
      write_capacity(cap);
      limit  = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
      pool_n = limit + 3;
      for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
      tx_wait_max = (p % 3 == 1) ? 0 : 9;
      rx_wait_max = (p % 3 == 2) ? 0 : 9;
      for (int n = 0; n < 75; n++) begin
        pick = $urandom_range(0, 99);
        op   = (pick < 3) ? lkvc_pkg::OP_CLEAR : (pick < 45) ? lkvc_pkg::OP_PUT :
               (pick < 75) ? lkvc_pkg::OP_GET : lkvc_pkg::OP_CONTAINS;
        // mostly reuse pooled keys to get hits; some wide random keys for bit toggling
        key  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_n - 1)]
                                              : KEY_W'($urandom);
        send_request(op, key, VAL_W'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d requests over %0d capacity writes", n_sent, n_cap_writes);
    $display("checked %0d replies with %0d hits and %0d evictions",
             mirror.checked, mirror.hits, mirror.evictions);
    if (mirror.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== lru_key_value_cache_unit.f =====
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_lookup.sv
rtl/core/lru_key_value_cache_unit.sv
tb/sv/tb_top.sv
